### design/distinct_value_counter_core_defines.svh
// Assertion macros shared by the distinct value counter RTL.
`ifndef DISTINCT_VALUE_COUNTER_CORE_DEFINES_SVH
`define DISTINCT_VALUE_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DVC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dvc_pkg.sv
// Package with types and constants of the distinct value counter.
`timescale 1ns / 1ps
package dvc_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int DUMP_LIM    = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;
  localparam int IW          = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FW          = $clog2(CAPACITY + 1);

  localparam logic       FUNC_SAMPLE = 1'b0;
  localparam logic       FUNC_DUMP   = 1'b1;

  localparam logic [2:0] ST_COUNTED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DUMP     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic               func;
    logic signed [31:0] value;
  } dvc_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] entry_value;
    logic [31:0]        entry_count;
    logic [3:0]         slot;
    logic               last;
  } dvc_out_t;

  typedef struct packed {
    logic shift;
    logic upd;
    logic ins;
  } cell_ctrl_t;

endpackage

### design/dvc_cell.sv
// One table cell: a stored value and its count, with match and rotate.
`timescale 1ns / 1ps
module dvc_cell
  import dvc_pkg::*;
(
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               filled,
  input  logic signed [31:0] sample,
  input  logic signed [31:0] nb_value,
  input  logic [31:0]        nb_count,
  output logic               hit,
  output logic signed [31:0] value,
  output logic [31:0]        count,
  output logic [31:0]        count_inc
);

  assign hit       = filled && (value == sample);
  assign count_inc = (count == '1) ? count : count + 32'd1;

  always_ff @(posedge clk) begin
    priority if (ctrl.shift) begin
      value <= nb_value;
      count <= nb_count;
    end else if (ctrl.ins) begin
      value <= sample;
      count <= 32'd1;
    end else if (ctrl.upd && hit) begin
      count <= count_inc;
    end else begin
      value <= value;
      count <= count;
    end
  end

endmodule

### design/distinct_value_counter_core.sv
// Top level of the distinct value counter: cell row, fill count, dump sequencer.
//
// Usage:
//   Command channel: start with req (func, value); a command transfers at a
//   rising edge with start high and busy low.
//   Result channel: valid strobes for one cycle with rsp; the receiver
//   cannot stall, so every strobe is a transfer.
//   A sample (func 0) is matched against all filled cells at once and its
//   single result appears in the cycle after the transfer; while busy is
//   low a new sample can be taken every cycle, and it sees the table as
//   left by the one before. A dump (func 1) of a non-empty table rotates
//   the cell row toward cell 0 with busy high; results stream from cell 0
//   one per cycle once the dumping flag is set and rsp has loaded cell 0,
//   first entry first, the last one marked. A dump of an empty table gives
//   one empty result in the cycle after the transfer and does not raise busy.
//   Reset clears the fill count and the sequencer; the cells hold no reset.
`timescale 1ns / 1ps
`include "distinct_value_counter_core_defines.svh"
module distinct_value_counter_core
  import dvc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dvc_in_t  req,
  output logic     busy,
  output logic     valid,
  output dvc_out_t rsp
);

  logic [FW-1:0]      fill;
  logic               dumping;
  logic [IW-1:0]      dcnt;
  dvc_out_t           rsp_next;

  cell_ctrl_t         ctrl   [CAPACITY];
  logic               hit    [CAPACITY];
  logic signed [31:0] cvalue [CAPACITY];
  logic [31:0]        ccount [CAPACITY];
  logic [31:0]        cinc   [CAPACITY];

  logic               sample_en;
  logic               dump_go;
  logic               any_hit;
  logic [31:0]        hit_count;
  logic [IW-1:0]      hit_slot;
  logic               full;
  logic               ins_en;
  logic [FW-1:0]      dump_n;
  logic               emit;
  logic               dump_last;

  assign busy      = dumping;
  assign sample_en = start && !busy && (req.func == FUNC_SAMPLE);
  assign dump_go   = start && !busy && (req.func == FUNC_DUMP);
  assign full      = (fill == FW'(CAPACITY));
  assign ins_en    = sample_en && !any_hit && !full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ctrl[i].shift = dumping;
    assign ctrl[i].upd   = sample_en;
    assign ctrl[i].ins   = ins_en && (FW'(i) == fill);

    dvc_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .filled    (FW'(i) < fill),
      .sample    (req.value),
      .nb_value  (cvalue[(i + 1) % CAPACITY]),
      .nb_count  (ccount[(i + 1) % CAPACITY]),
      .hit       (hit[i]),
      .value     (cvalue[i]),
      .count     (ccount[i]),
      .count_inc (cinc[i])
    );
  end

  always_comb begin
    any_hit   = 1'b0;
    hit_count = '0;
    hit_slot  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        any_hit   = 1'b1;
        hit_count = hit_count | cinc[i];
        hit_slot  = hit_slot | IW'(i);
      end
    end
  end

  assign dump_n    = (fill > FW'(DUMP_LIM)) ? FW'(DUMP_LIM) : fill;
  assign emit      = FW'(dcnt) < dump_n;
  assign dump_last = (FW'(dcnt) + FW'(1)) == dump_n;

  always_comb begin
    priority if (sample_en) begin
      rsp_next.entry_value = req.value;
      rsp_next.last        = 1'b1;
      priority if (any_hit) begin
        rsp_next.status      = ST_COUNTED;
        rsp_next.entry_count = hit_count;
        rsp_next.slot        = 4'(hit_slot);
      end else if (full) begin
        rsp_next.status      = ST_FULL;
        rsp_next.entry_count = 32'd0;
        rsp_next.slot        = 4'd0;
      end else begin
        rsp_next.status      = ST_INSERTED;
        rsp_next.entry_count = 32'd1;
        rsp_next.slot        = 4'(fill);
      end
    end else if (dump_go) begin
      rsp_next.status      = ST_EMPTY;
      rsp_next.entry_value = '0;
      rsp_next.entry_count = 32'd0;
      rsp_next.slot        = 4'd0;
      rsp_next.last        = 1'b1;
    end else if (dumping) begin
      rsp_next.status      = ST_DUMP;
      rsp_next.entry_value = cvalue[0];
      rsp_next.entry_count = ccount[0];
      rsp_next.slot        = 4'(dcnt);
      rsp_next.last        = dump_last;
    end else begin
      rsp_next = rsp;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      fill    <= '0;
      dumping <= 1'b0;
      dcnt    <= '0;
    end else begin
      priority if (sample_en) begin
        valid <= 1'b1;
        if (ins_en) begin
          fill <= fill + FW'(1);
        end
      end else if (dump_go) begin
        valid <= (fill == '0);
        if (fill != '0) begin
          dumping <= 1'b1;
          dcnt    <= '0;
        end
      end else if (dumping) begin
        valid <= emit;
        dcnt  <= dcnt + IW'(1);
        if (dcnt == IW'(CAPACITY - 1)) begin
          dumping <= 1'b0;
        end
      end else begin
        valid <= 1'b0;
      end
    end
  end

  `DVC_ASSERT_NOW(a_fill_bound, 1'b1, fill <= FW'(CAPACITY), "fill count beyond capacity")
  `DVC_ASSERT_NEXT(a_insert_grows, ins_en, fill == $past(fill) + FW'(1), "insert lost")
  `DVC_ASSERT_NEXT(a_sample_result, sample_en, valid && rsp.last, "sample gave no result")
  `DVC_ASSERT_NEXT(a_dump_ends, dumping && dcnt == IW'(CAPACITY - 1), !busy, "dump overran")

endmodule
